FILE: rtl/core/dsrc_pkg.sv
// Package for the digit-sum range counter: constants, word types and the
// table geometry. It depends on nothing else.
`default_nettype none
package dsrc_pkg;
  localparam int DIGITS  = 16;
  localparam int MAXSUM  = 9 * DIGITS;
  localparam int NSTATE  = 3;
  localparam int LAYER   = (MAXSUM + 1) * NSTATE;
  localparam int VW      = 54;
  localparam int SUMW    = $clog2(MAXSUM + 10);
  localparam int AW      = $clog2(2 * LAYER);
  localparam int DW      = $clog2(DIGITS);
  localparam int DCW     = $clog2(DIGITS + 1);

  typedef struct packed {
    logic [VW-1:0] low_bound;
    logic [VW-1:0] high_bound;
    logic [7:0]    target_sum;
  } dsrc_in_t;

  typedef struct packed {
    logic [VW-1:0] match_count;
    logic [VW-1:0] smallest_match;
    logic          found;
  } dsrc_out_t;

  // Largest value that fits in DIGITS decimal digits.
  function automatic logic [63:0] max_val();
    logic [63:0] v;
    v = 64'd0;
    for (int i = 0; i < DIGITS; i++) v = v * 64'd10 + 64'd9;
    return v;
  endfunction

  // Times ten, as two shifts and an add.
  function automatic logic [VW-1:0] x10(input logic [VW-1:0] v);
    return (v << 3) + (v << 1);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/digit_sum_range_count_min.sv
// Digit-sum range counter, top level. Counts integers in [low, high] with a
// given decimal digit sum and finds the least one. Uses dsrc_pkg.
//
// Usage: one input word (in_valid/in_stall/in_data) carries the two bounds
// and the target sum; exactly one result word (out_valid/out_stall/out_data)
// follows. One word is processed at a time: in_stall is high from
// acceptance until the result has been taken from the output register.
// Bounds are saturated to DIGITS nines and split into digits by repeated
// subtraction of powers of ten. A clearing pass then writes the first
// count/minimum layer (LAYER = 435 entries). For each remaining digit the
// next layer is cleared in a pass over its 435 entries, then the old layer
// is swept state by state, one digit choice a cycle, in a
// read-modify-write over one synchronous memory for counts and one for
// minima. An update to an entry written the cycle before is forwarded.
// Each state is read, then updated once for each of its digit choices.
// Reset empties the output register and returns the sequencer to idle.
// A stalled output holds its word and the block takes nothing new until
// it leaves.
`default_nettype none
module digit_sum_range_count_min
  import dsrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dsrc_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output dsrc_out_t      out_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SPLIT = 4'd1, S_PREF = 4'd2,
    S_CLR = 4'd3, S_SEED = 4'd4, S_RD = 4'd5, S_UPD = 4'd6,
    S_FIN = 4'd7, S_FIN2 = 4'd8, S_OUT = 4'd9;

  logic [3:0]    st_r;
  logic [VW-1:0] lo_r, hi_r, rem_lo_r, rem_hi_r, pv_r, p10_r;
  logic [7:0]    tgt_r;
  logic [DW-1:0] di_r;
  logic [DCW-1:0] p_r;
  logic [SUMW-1:0] ps_r;
  logic [3:0]    dl_r, dh_r;
  logic [3:0]    low_digit_store [DIGITS];
  logic [3:0]    high_digit_store [DIGITS];
  logic          cur_r;
  logic [SUMW-1:0] s_r;
  logic [1:0]    t_r;
  logic [3:0]    d_r, dto_r;
  logic [AW-1:0] cidx_r;
  logic [VW-1:0] c_r, base_r, acc_c_r, best_r;
  logic          fin_t_r;
  logic [1:0]    fin_st_r;
  dsrc_out_t     res_r;

  // Count and minimum memories, one read port and one write port each.
  logic [VW-1:0] cnt_mem [2*LAYER];
  logic [VW-1:0] min_mem [2*LAYER];
  logic [AW-1:0] ra, wa;
  logic          we;
  logic [VW-1:0] wc, wm, rc_q, rm_q;
  always_ff @(posedge clk) begin
    if (we) begin
      cnt_mem[wa] <= wc;
      min_mem[wa] <= wm;
    end
    rc_q <= cnt_mem[ra];
    rm_q <= min_mem[ra];
  end

  function automatic logic [AW-1:0] slot(input logic l, input logic [SUMW-1:0] s,
                                         input logic [1:0] t);
    logic [AW+1:0] k;
    k = ((AW+2)'(l) * (AW+2)'(MAXSUM + 1) + (AW+2)'(s)) * (AW+2)'(NSTATE) + (AW+2)'(t);
    return k[AW-1:0];
  endfunction

  // Feed pipeline: an update reads its entry, then writes it back in the next cycle.
  logic          f_v_r;
  logic [AW-1:0] f_a_r;
  logic [VW-1:0] f_c_r, f_m_r, l_c_r, l_m_r;
  logic          l_v_r;
  logic [AW-1:0] l_a_r;
  logic          fd_v;
  logic [AW-1:0] fd_a;
  logic [VW-1:0] fd_c, fd_m;
  logic [VW-1:0] oc, om, nc, nm;
  logic          pipe_busy;
  assign pipe_busy = f_v_r;

  // Old value, forwarded from the last write when it hit the same entry.
  always_comb begin
    oc = rc_q; om = rm_q;
    if (l_v_r && l_a_r == f_a_r) begin oc = l_c_r; om = l_m_r; end
    nc = oc + f_c_r;
    nm = (f_m_r < om) ? f_m_r : om;
  end

  // Feed request from the sequencer for the current step.
  logic [SUMW-1:0] ns;
  logic [1:0] nst;
  logic [VW-1:0] nval;
  logic clrw;
  logic [AW-1:0] clra;
  always_comb begin
    fd_v = 1'b0; fd_a = '0; fd_c = c_r; fd_m = '0;
    ns = s_r + SUMW'(d_r); nst = 2'd1; nval = base_r + VW'(d_r);
    clrw = 1'b0; clra = '0;
    if (st_r == S_SEED) begin
      ns = ps_r + SUMW'(d_r);
      nst = (d_r == dl_r) ? 2'd0 : ((d_r == dh_r) ? 2'd2 : 2'd1);
      fd_v = 1'b1; fd_c = VW'(1); fd_m = nval;
      fd_a = slot(cur_r, ns, nst);
    end else if (st_r == S_UPD) begin
      if (t_r == 2'd0 && d_r == dl_r) nst = 2'd0;
      else if (t_r == 2'd2 && d_r == dh_r) nst = 2'd2;
      fd_v = (c_r != '0) && (ns <= SUMW'(MAXSUM));
      fd_m = nval;
      fd_a = slot(~cur_r, ns, nst);
    end
    if (st_r == S_CLR) begin clrw = 1'b1; clra = cidx_r; end
    // The next layer is cleared once the last feeds have landed.
    if (st_r == S_FIN && !pipe_busy && p_r != DCW'(DIGITS) && !fin_t_r) begin
      clrw = 1'b1; clra = cidx_r;
    end
  end

  // Write port: clears only run while no feed is in flight.
  always_comb begin
    we = f_v_r; wa = f_a_r; wc = nc; wm = nm;
    if (clrw) begin we = 1'b1; wa = clra; wc = '0; wm = '1; end
  end

  // Read port address.
  always_comb begin
    ra = fd_a;
    if (st_r == S_RD) ra = slot(cur_r, s_r, t_r);
    if (st_r == S_FIN || st_r == S_FIN2) ra = slot(cur_r, SUMW'(tgt_r), fin_st_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
      l_v_r <= 1'b0;
    end else begin
      f_v_r <= fd_v && !clrw;
      l_v_r <= we;
    end
    f_a_r <= fd_a; f_c_r <= fd_c; f_m_r <= fd_m;
    l_a_r <= wa; l_c_r <= wc; l_m_r <= wm;
  end

  // Power of ten for digit position i (MSB first), evaluated on constants only.
  function automatic logic [VW-1:0] pow10(input int i);
    logic [VW-1:0] v;
    v = VW'(1);
    for (int k = 0; k < DIGITS - 1 - i; k++) v = x10(v);
    return v;
  endfunction

  // Place values as a constant table indexed by digit position.
  logic [VW-1:0] p10_tab [DIGITS];
  for (genvar g = 0; g < DIGITS; g++) begin : g_p10
    localparam logic [VW-1:0] P10 = pow10(g);
    assign p10_tab[g] = P10;
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_data  = res_r;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (in_valid) begin
          lo_r <= (64'(in_data.low_bound) > max_val()) ? VW'(max_val()) : in_data.low_bound;
          hi_r <= (64'(in_data.high_bound) > max_val()) ? VW'(max_val()) : in_data.high_bound;
          rem_lo_r <= (64'(in_data.low_bound) > max_val()) ? VW'(max_val()) : in_data.low_bound;
          rem_hi_r <= (64'(in_data.high_bound) > max_val()) ? VW'(max_val()) :
                      in_data.high_bound;
          tgt_r <= in_data.target_sum;
          di_r <= '0; dl_r <= '0; dh_r <= '0;
          p10_r <= p10_tab[0];
          st_r <= S_SPLIT;
        end
        S_SPLIT: begin
          // Subtract the place value until each remainder is below it.
          if (rem_lo_r >= p10_r || rem_hi_r >= p10_r) begin
            if (rem_lo_r >= p10_r) begin rem_lo_r <= rem_lo_r - p10_r; dl_r <= dl_r + 4'd1; end
            if (rem_hi_r >= p10_r) begin rem_hi_r <= rem_hi_r - p10_r; dh_r <= dh_r + 4'd1; end
          end else begin
            low_digit_store[di_r]  <= dl_r;
            high_digit_store[di_r] <= dh_r;
            dl_r <= '0; dh_r <= '0;
            if (di_r == DW'(DIGITS - 1)) begin
              p_r <= '0; ps_r <= '0; pv_r <= '0; st_r <= S_PREF;
            end else begin
              di_r <= di_r + DW'(1);
              p10_r <= p10_tab[di_r + DW'(1)];
            end
          end
        end
        S_PREF: begin
          if (lo_r > hi_r || tgt_r > 8'(MAXSUM)) begin
            res_r <= '0;
            st_r <= S_OUT;
          end else if (p_r == DCW'(DIGITS)) begin
            res_r <= '{match_count: VW'(ps_r == SUMW'(tgt_r)),
                       smallest_match: (ps_r == SUMW'(tgt_r)) ? lo_r : '0,
                       found: (ps_r == SUMW'(tgt_r))};
            st_r <= S_OUT;
          end else if (low_digit_store[p_r[DW-1:0]] == high_digit_store[p_r[DW-1:0]]) begin
            ps_r <= ps_r + SUMW'(low_digit_store[p_r[DW-1:0]]);
            pv_r <= x10(pv_r) + VW'(low_digit_store[p_r[DW-1:0]]);
            p_r <= p_r + DCW'(1);
          end else begin
            cur_r <= 1'b0; cidx_r <= slot(1'b0, '0, '0); st_r <= S_CLR;
          end
        end
        S_CLR: begin
          if (cidx_r == slot(cur_r, SUMW'(MAXSUM), 2'd2)) begin
            dl_r <= low_digit_store[p_r[DW-1:0]];
            dh_r <= high_digit_store[p_r[DW-1:0]];
            d_r <= low_digit_store[p_r[DW-1:0]];
            base_r <= x10(pv_r);
            st_r <= S_SEED;
          end else cidx_r <= cidx_r + AW'(1);
        end
        S_SEED: begin
          if (d_r == dh_r) begin
            cidx_r <= slot(~cur_r, '0, '0);
            st_r <= S_FIN;  // re-dispatched below via p_r
            p_r <= p_r + DCW'(1);
            fin_st_r <= 2'd0; acc_c_r <= '0; best_r <= '1; fin_t_r <= 1'b0;
          end else d_r <= d_r + 4'd1;
        end
        S_RD: begin
          // Wait for pending feeds to land, then for the read of state (s,t).
          if (!pipe_busy) begin
            if (fin_t_r) begin
              c_r <= rc_q;
              base_r <= x10(rm_q);
              d_r <= (t_r == 2'd0) ? dl_r : 4'd0;
              dto_r <= (t_r == 2'd2) ? dh_r : 4'd9;
              st_r <= S_UPD;
            end
            fin_t_r <= ~fin_t_r;
          end
        end
        S_UPD: begin
          // An empty state issues nothing and moves straight on.
          if (d_r == dto_r || c_r == '0) begin
            if (t_r == 2'd2) begin
              t_r <= 2'd0;
              if (s_r == SUMW'(MAXSUM)) begin
                cur_r <= ~cur_r; p_r <= p_r + DCW'(1);
                cidx_r <= slot(cur_r, '0, '0);
                st_r <= S_FIN; fin_st_r <= 2'd0; acc_c_r <= '0; best_r <= '1;
                fin_t_r <= 1'b0;
              end else begin s_r <= s_r + SUMW'(1); st_r <= S_RD; end
            end else begin t_r <= t_r + 2'd1; st_r <= S_RD; end
          end else d_r <= d_r + 4'd1;
        end
        S_FIN: begin
          // Either start the next digit layer or collect the result.
          if (!pipe_busy) begin
            if (p_r != DCW'(DIGITS) && !fin_t_r) begin
              if (cidx_r == slot(~cur_r, SUMW'(MAXSUM), 2'd2)) begin
                dl_r <= low_digit_store[p_r[DW-1:0]];
                dh_r <= high_digit_store[p_r[DW-1:0]];
                s_r <= '0; t_r <= 2'd0; st_r <= S_RD;
              end else cidx_r <= cidx_r + AW'(1);
            end else begin
              fin_t_r <= 1'b1; st_r <= S_FIN2;
            end
          end
        end
        S_FIN2: begin
          if (fin_t_r) fin_t_r <= 1'b0;
          else begin
            acc_c_r <= acc_c_r + rc_q;
            if (rc_q != '0 && rm_q < best_r) best_r <= rm_q;
            if (fin_st_r == 2'd2) begin
              res_r <= '{match_count: acc_c_r + rc_q,
                         smallest_match: ((acc_c_r + rc_q) == '0) ? '0 :
                           ((rc_q != '0 && rm_q < best_r) ? rm_q : best_r),
                         found: (acc_c_r + rc_q) != '0};
              st_r <= S_OUT;
            end else begin fin_st_r <= fin_st_r + 2'd1; fin_t_r <= 1'b1; end
          end
        end
        S_OUT: if (!out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/dsrc_checker.sv
// Port-level checker for the digit-sum range counter, bound to the top
// level. Depends on dsrc_pkg.
`default_nettype none
module dsrc_checker
  import dsrc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire dsrc_out_t out_data
);
  // A found flag of zero always comes with a zero count and smallest value.
  a_nofind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_count == '0 &&
    out_data.smallest_match == '0) else $error("empty result not zero");
  // A found flag means a non-zero count.
  a_find: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.match_count != '0)
    else $error("found with zero count");
  // The input is refused while a result word waits.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  // An accepted input word makes the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("not busy after input word");
  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled word changed");
endmodule

bind digit_sum_range_count_min dsrc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
